[design/iat_pkg.sv]
// Package for the identifier activity tracker.
// Holds the request, result, entry and configuration types and the event codes.
// No dependencies.
package iat_pkg;

  localparam logic OP_DETECT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [2:0] EV_COUNTED   = 3'd0;
  localparam logic [2:0] EV_INSERTED  = 3'd1;
  localparam logic [2:0] EV_DROPPED   = 3'd2;
  localparam logic [2:0] EV_REMOVED   = 3'd3;
  localparam logic [2:0] EV_ACTIVATED = 3'd4;
  localparam logic [2:0] EV_TICK_DONE = 3'd5;

  localparam logic [2:0] REG_REMOVE_RATIO = 3'd0;
  localparam logic [2:0] REG_ACTIVE_RATIO = 3'd1;
  localparam logic [2:0] REG_MIN_FRAMES   = 3'd2;
  localparam logic [2:0] REG_AGE_LIMIT    = 3'd3;
  localparam logic [2:0] REG_AGE_BASE     = 3'd4;

  localparam int DIV_W = 24;

  typedef struct packed {
    logic        operation;
    logic [15:0] ident;
  } req_t;

  typedef struct packed {
    logic [15:0] ident_res;
    logic [2:0]  event_res;
    logic        was_active;
    logic [15:0] occurrences;
    logic [7:0]  frame_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  frames;
    logic [15:0] occ;
    logic [15:0] ident;
  } entry_t;

  typedef struct packed {
    logic [8:0] remove_ratio;
    logic [8:0] active_ratio;
    logic [7:0] min_frames_active;
    logic [7:0] age_limit;
    logic [7:0] age_base;
  } cfg_t;

endpackage

[design/iat_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module iat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/iat_div.sv]
// Restoring divider, one quotient bit per cycle, used for count rescaling.
// Depends on iat_pkg.
module iat_div
  import iat_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [7:0]       divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W);

  logic          running;
  logic [CW-1:0] cnt;
  logic [DIV_W-1:0] dvd;
  logic [7:0]    rem;
  logic [7:0]    dsr;
  logic [8:0]    trial;
  logic          qbit;

  assign trial    = {rem, dvd[DIV_W-1]};
  assign qbit     = (trial >= {1'b0, dsr});
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        dvd     <= dividend;
        rem     <= '0;
        dsr     <= divisor;
      end else if (running) begin
        rem <= qbit ? 8'(trial - {1'b0, dsr}) : trial[7:0];
        dvd <= {dvd[DIV_W-2:0], qbit};
        if (cnt == CW'(DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

[design/iat_front.sv]
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on iat_pkg.
module iat_front
  import iat_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  input  logic pop,
  output logic q_valid,
  output req_t q_data
);

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= req;
        wr_ptr <= !wr_ptr;
      end
      if (pop && q_valid) begin
        rd_ptr <= !rd_ptr;
      end
      count <= 2'(count + 2'(push) - 2'(pop && q_valid));
    end
  end

endmodule

[design/iat_back.sv]
// Back end: walks the entry table for each queued request and issues results.
// Depends on iat_pkg, iat_ram and iat_div.
module iat_back
  import iat_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_valid,
  input  req_t q_data,
  output logic pop,
  output logic res_valid,
  output res_t res
);

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_D_RD, S_D_CMP, S_D_END, S_T_RD, S_T_AGE, S_T_DIV, S_T_EVAL, S_T_DONE
  } state_t;

  state_t                 state;
  logic [IDXW-1:0]        idx;
  logic [IDXW-1:0]        free_idx;
  logic                   free_found;
  req_t                   cur;
  entry_t                 ent;
  logic [15:0]            occ_r;
  logic [7:0]             fr_r;
  logic [TABLE_DEPTH-1:0] valid;

  logic       we;
  logic [IDXW-1:0] waddr;
  entry_t     wdata;
  entry_t     rdata;
  logic       div_start;
  logic [DIV_W-1:0] dividend;
  logic       div_done;
  logic [DIV_W-1:0] quotient;
  logic [15:0] occ_inc;
  logic [23:0] lhs;
  logic [16:0] rm_prod;
  logic [16:0] ac_prod;
  logic        do_remove;
  logic        do_activate;

  iat_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(idx), .rdata(rdata)
  );

  iat_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend),
    .divisor(rdata.frames), .done(div_done), .quotient(quotient)
  );

  assign pop      = (state == S_IDLE);
  assign occ_inc  = (rdata.occ == 16'hFFFF) ? rdata.occ : rdata.occ + 16'd1;
  assign dividend = DIV_W'(rdata.occ) * DIV_W'(cfg.age_base);
  assign lhs      = {occ_r, 8'd0};
  assign rm_prod  = cfg.remove_ratio * fr_r;
  assign ac_prod  = cfg.active_ratio * fr_r;
  assign do_remove   = (lhs < 24'(rm_prod));
  assign do_activate = (lhs > 24'(ac_prod)) && !ent.active &&
                       (fr_r > cfg.min_frames_active);
  assign div_start = (state == S_T_AGE) && (rdata.frames > cfg.age_limit);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    unique case (state)
      S_D_CMP: begin
        we        = (rdata.ident == cur.ident);
        wdata.occ = occ_inc;
      end
      S_D_END: begin
        we    = free_found;
        waddr = free_idx;
        wdata = '{active: 1'b0, frames: 8'd1, occ: 16'd1, ident: cur.ident};
      end
      S_T_EVAL: begin
        we    = 1'b1;
        wdata = '{active: ent.active | do_activate, frames: fr_r, occ: occ_r,
                  ident: ent.ident};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      res_valid <= 1'b0;
      idx       <= '0;
      free_found <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur        <= q_data;
            idx        <= '0;
            free_found <= 1'b0;
            state      <= (q_data.operation == OP_TICK) ? S_T_RD : S_D_RD;
          end
        end
        S_D_RD: begin
          if (valid[idx]) begin
            state <= S_D_CMP;
          end else begin
            if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= idx;
            end
            if (idx == LAST_IDX) begin
              state <= S_D_END;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_D_CMP: begin
          if (rdata.ident == cur.ident) begin
            res_valid <= 1'b1;
            res <= '{ident_res: cur.ident, event_res: EV_COUNTED, was_active: 1'b0,
                     occurrences: occ_inc, frame_count: rdata.frames, last: 1'b1};
            state <= S_IDLE;
          end else if (idx == LAST_IDX) begin
            state <= S_D_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_D_RD;
          end
        end
        S_D_END: begin
          res_valid <= 1'b1;
          if (free_found) begin
            valid[free_idx] <= 1'b1;
            res <= '{ident_res: cur.ident, event_res: EV_INSERTED, was_active: 1'b0,
                     occurrences: 16'd1, frame_count: 8'd1, last: 1'b1};
          end else begin
            res <= '{ident_res: cur.ident, event_res: EV_DROPPED, was_active: 1'b0,
                     occurrences: 16'd0, frame_count: 8'd0, last: 1'b1};
          end
          state <= S_IDLE;
        end
        S_T_RD: begin
          if (valid[idx]) begin
            state <= S_T_AGE;
          end else if (idx == LAST_IDX) begin
            state <= S_T_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_T_AGE: begin
          ent <= rdata;
          if (rdata.frames > cfg.age_limit) begin
            state <= S_T_DIV;
          end else begin
            occ_r <= rdata.occ;
            fr_r  <= (rdata.frames == 8'hFF) ? rdata.frames : rdata.frames + 8'd1;
            state <= S_T_EVAL;
          end
        end
        S_T_DIV: begin
          if (div_done) begin
            occ_r <= (quotient > DIV_W'(16'hFFFF)) ? 16'hFFFF : quotient[15:0];
            fr_r  <= (cfg.age_base == 8'hFF) ? cfg.age_base : cfg.age_base + 8'd1;
            state <= S_T_EVAL;
          end
        end
        S_T_EVAL: begin
          if (do_remove) begin
            valid[idx] <= 1'b0;
            res_valid  <= 1'b1;
            res <= '{ident_res: ent.ident, event_res: EV_REMOVED,
                     was_active: ent.active, occurrences: occ_r, frame_count: fr_r,
                     last: 1'b0};
          end else if (do_activate) begin
            res_valid <= 1'b1;
            res <= '{ident_res: ent.ident, event_res: EV_ACTIVATED, was_active: 1'b0,
                     occurrences: occ_r, frame_count: fr_r, last: 1'b0};
          end
          if (idx == LAST_IDX) begin
            state <= S_T_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_T_RD;
          end
        end
        S_T_DONE: begin
          res_valid <= 1'b1;
          res <= '{ident_res: 16'd0, event_res: EV_TICK_DONE, was_active: 1'b0,
                   occurrences: 16'd0, frame_count: 8'd0, last: 1'b1};
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/id_activity_tracker_top.sv]
// Detect requests walk the table one entry at a time, reading each entry through the
// registered read port of the entry RAM and stopping at the first matching identifier.
// A tick request walks every entry, rescaling those whose frame count exceeds the age
// limit with the bit-serial divider; one request is worked at a time, two queue.
// Synchronous reset empties the table and the queue and restores register defaults.
// Results are strobed for one cycle and cannot be stalled.
module id_activity_tracker_top
  import iat_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  req_t        req,
  output logic        busy,
  output logic        res_valid,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  logic q_valid;
  req_t q_data;
  logic pop;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{remove_ratio: 9'd26, active_ratio: 9'd128, min_frames_active: 8'd50,
               age_limit: 8'd100, age_base: 8'd10};
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_REMOVE_RATIO: cfg.remove_ratio      <= pwdata[8:0];
        REG_ACTIVE_RATIO: cfg.active_ratio      <= pwdata[8:0];
        REG_MIN_FRAMES:   cfg.min_frames_active <= pwdata[7:0];
        REG_AGE_LIMIT:    cfg.age_limit         <= pwdata[7:0];
        REG_AGE_BASE:     cfg.age_base          <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_REMOVE_RATIO: prdata = {23'd0, cfg.remove_ratio};
      REG_ACTIVE_RATIO: prdata = {23'd0, cfg.active_ratio};
      REG_MIN_FRAMES:   prdata = {24'd0, cfg.min_frames_active};
      REG_AGE_LIMIT:    prdata = {24'd0, cfg.age_limit};
      REG_AGE_BASE:     prdata = {24'd0, cfg.age_base};
      default:          prdata = 32'd0;
    endcase
  end

  iat_front u_front (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .pop(pop), .q_valid(q_valid), .q_data(q_data)
  );

  iat_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_data(q_data),
    .pop(pop), .res_valid(res_valid), .res(res)
  );

endmodule

[design/iat_chk.sv]
// Port-level checks for the identifier activity tracker, bound to the top level.
// Depends on iat_pkg and id_activity_tracker_top.
module iat_chk
  import iat_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic busy,
  input logic res_valid,
  input res_t res
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid && !busy)
    else $error("output active right after reset");

  a_zero_counts: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.event_res == EV_DROPPED || res.event_res == EV_TICK_DONE)
    |-> res.occurrences == 16'd0 && res.frame_count == 8'd0)
    else $error("dropped or tick-done result carries counts");

  a_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last
    |-> res.event_res == EV_REMOVED || res.event_res == EV_ACTIVATED)
    else $error("non-final result of wrong kind");

  a_wa_removed: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.was_active |-> res.event_res == EV_REMOVED)
    else $error("was_active set on a result other than a removal");

endmodule

bind id_activity_tracker_top iat_chk u_chk (
  .clk(clk), .rst(rst), .busy(busy), .res_valid(res_valid), .res(res)
);
